/* rtl/xrrg_pkg.sv */
// Shared types and constants for the xorshift/rotate random generator.
// Used by every module of the block; depends on nothing else.
package xrrg_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned OP_W   = 3;

   // Request operation codes.
   localparam logic [OP_W-1:0] OP_RAW       = 3'd0;
   localparam logic [OP_W-1:0] OP_RANGE     = 3'd1;
   localparam logic [OP_W-1:0] OP_FRACTION  = 3'd2;
   localparam logic [OP_W-1:0] OP_FULL_SEED = 3'd3;
   localparam logic [OP_W-1:0] OP_SET_MAIN  = 3'd4;

   localparam logic [WORD_W-1:0] SIDE_INIT = 64'hCAFE_F00D_D15E_A5E5;

   // Shift of the fraction form: a 64-bit draw cut to 53 bits.
   localparam int unsigned FRAC_SHIFT = 11;

   // Number of radix-2 steps for a 64-bit remainder.
   localparam int unsigned DIV_STEPS = WORD_W;
   localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      KIND_RAW,
      KIND_RANGE,
      KIND_FRACTION
   } kind_type;

   // A classified draw handed from the front end to the back end.
   typedef struct packed {
      kind_type          kind;
      logic [WORD_W-1:0] main_word;
      logic [WORD_W-1:0] low_bound;
      logic [WORD_W-1:0] span;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCALE,
      BK_MUL,
      BK_DIV,
      BK_ADD,
      BK_DONE
   } back_state_type;

endpackage

/* rtl/xrrg_front.sv */
// Front end: holds the two generator words, accepts requests, advances the
// state for each draw and hands a classified job on. Uses xrrg_pkg.
module xrrg_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [xrrg_pkg::OP_W-1:0]         req_op,
   input  logic [xrrg_pkg::WORD_W-1:0]       req_low_bound,
   input  logic [xrrg_pkg::WORD_W-1:0]       req_high_bound,
   input  logic [xrrg_pkg::WORD_W-1:0]       req_seed_value,
   output logic                              job_push,
   output xrrg_pkg::job_type                 job_data,
   input  logic                              queue_full
);

   logic [xrrg_pkg::WORD_W-1:0] main_ff, main_in;
   logic [xrrg_pkg::WORD_W-1:0] side_ff, side_in;
   logic [xrrg_pkg::WORD_W-1:0] next_main, next_side;
   logic [xrrg_pkg::WORD_W-1:0] side_shift, side_mix, main_mix;
   logic                        accept;

   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   // One step of the xorshift/rotate recurrence.
   always_comb begin
      side_shift = {side_ff[xrrg_pkg::WORD_W-18:0], 17'd0};
      side_mix   = side_ff ^ main_ff;
      main_mix   = main_ff ^ side_mix;
      next_side  = side_mix ^ side_shift;
      next_main  = {main_mix[18:0], main_mix[xrrg_pkg::WORD_W-1:19]};
   end

   always_comb begin
      main_in           = main_ff;
      side_in           = side_ff;
      job_push          = 1'b0;
      job_data.kind     = xrrg_pkg::KIND_RAW;
      job_data.main_word = main_ff;
      job_data.low_bound = req_low_bound;
      job_data.span     = req_high_bound - req_low_bound + 64'd1;
      if (accept) begin
         case (req_op)
            xrrg_pkg::OP_RAW, xrrg_pkg::OP_RANGE, xrrg_pkg::OP_FRACTION: begin
               job_push = 1'b1;
               main_in  = next_main;
               side_in  = next_side;
               if (req_op == xrrg_pkg::OP_RANGE) begin
                  job_data.kind = xrrg_pkg::KIND_RANGE;
               end else if (req_op == xrrg_pkg::OP_FRACTION) begin
                  job_data.kind = xrrg_pkg::KIND_FRACTION;
               end
            end
            xrrg_pkg::OP_FULL_SEED: begin
               main_in = req_seed_value;
               side_in = xrrg_pkg::SIDE_INIT;
            end
            xrrg_pkg::OP_SET_MAIN: begin
               main_in = req_seed_value;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_ff <= '0;
         side_ff <= xrrg_pkg::SIDE_INIT;
      end else begin
         main_ff <= main_in;
         side_ff <= side_in;
      end
   end

endmodule

/* rtl/xrrg_queue.sv */
// Short job queue between the front end and the back end.
// Uses xrrg_pkg for the job type.
module xrrg_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  xrrg_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output xrrg_pkg::job_type pop_data,
   output logic              empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   xrrg_pkg::job_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/xrrg_back.sv */
// Back end: scrambles a drawn state word into the output value, reduces it
// into a range with a radix-2 remainder unit, and holds the result register.
// Uses xrrg_pkg.
module xrrg_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   input  xrrg_pkg::job_type           job_data,
   output logic                        job_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [xrrg_pkg::WORD_W-1:0] rsp_value
);

   localparam int unsigned W = xrrg_pkg::WORD_W;

   xrrg_pkg::back_state_type state_ff, state_in;
   xrrg_pkg::kind_type       kind_ff, kind_in;
   logic [W-1:0]             low_ff, low_in;
   logic [W-1:0]             span_ff, span_in;
   logic [W-1:0]             work_ff, work_in;
   logic [W:0]               rem_ff, rem_in;
   logic [xrrg_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]             res_ff, res_in;
   logic                     out_valid_ff, out_valid_in;
   logic [W-1:0]             out_value_ff, out_value_in;

   logic [W-1:0]             times5, times9;
   logic [W:0]               rem_shift;
   logic [W+1:0]             rem_diff;
   logic                     out_free;

   assign rsp_empty = !out_valid_ff;
   assign rsp_value = out_value_ff;
   assign out_free  = !out_valid_ff || rsp_pop;

   always_comb begin
      times5    = work_ff + {work_ff[W-3:0], 2'b00};
      times9    = work_ff + {work_ff[W-4:0], 3'b000};
      rem_shift = {rem_ff[W-1:0], work_ff[W-1]};
      rem_diff  = {1'b0, rem_shift} - {2'b00, span_ff};
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      low_in       = low_ff;
      span_in      = span_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_value_in = out_value_ff;
      job_pop      = 1'b0;
      case (state_ff)
         xrrg_pkg::BK_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               kind_in  = job_data.kind;
               low_in   = job_data.low_bound;
               span_in  = job_data.span;
               work_in  = job_data.main_word;
               state_in = xrrg_pkg::BK_SCALE;
            end
         end
         xrrg_pkg::BK_SCALE: begin
            // rotl(main * 5, 7)
            work_in  = {times5[W-8:0], times5[W-1:W-7]};
            state_in = xrrg_pkg::BK_MUL;
         end
         xrrg_pkg::BK_MUL: begin
            work_in = times9;
            cnt_in  = '0;
            if (kind_ff == xrrg_pkg::KIND_RANGE) begin
               if (span_ff == '0) begin
                  // Full range: the draw is added to the low bound unreduced.
                  rem_in   = {1'b0, times9};
                  state_in = xrrg_pkg::BK_ADD;
               end else begin
                  rem_in   = '0;
                  state_in = xrrg_pkg::BK_DIV;
               end
            end else if (kind_ff == xrrg_pkg::KIND_FRACTION) begin
               res_in   = times9 >> xrrg_pkg::FRAC_SHIFT;
               state_in = xrrg_pkg::BK_DONE;
            end else begin
               res_in   = times9;
               state_in = xrrg_pkg::BK_DONE;
            end
         end
         xrrg_pkg::BK_DIV: begin
            // One restoring step: shift in the next dividend bit, subtract if it fits.
            if (rem_diff[W+1]) begin
               rem_in = rem_shift;
            end else begin
               rem_in = rem_diff[W:0];
            end
            work_in = {work_ff[W-2:0], 1'b0};
            cnt_in  = cnt_ff + xrrg_pkg::CNT_W'(1);
            if (cnt_ff == xrrg_pkg::CNT_W'(xrrg_pkg::DIV_STEPS - 1)) begin
               state_in = xrrg_pkg::BK_ADD;
            end
         end
         xrrg_pkg::BK_ADD: begin
            res_in   = low_ff + rem_ff[W-1:0];
            state_in = xrrg_pkg::BK_DONE;
         end
         xrrg_pkg::BK_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = res_ff;
               state_in     = xrrg_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = xrrg_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      low_ff       <= low_in;
      span_ff      <= span_in;
      work_ff      <= work_in;
      rem_ff       <= rem_in;
      res_ff       <= res_in;
      out_value_ff <= out_value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xrrg_pkg::BK_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // The step counter only runs while a remainder is being formed.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != xrrg_pkg::BK_DIV) |-> (cnt_ff == '0))
      else $error("step counter running outside the division");

   // The partial remainder stays below a nonzero span throughout the division.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == xrrg_pkg::BK_DIV) |->
      (span_ff != '0 && rem_ff < {1'b0, span_ff}))
      else $error("partial remainder out of bounds");

   // Only range jobs reach the final addition.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == xrrg_pkg::BK_ADD) |-> (kind_ff == xrrg_pkg::KIND_RANGE))
      else $error("non-range job in addition stage");

   // A finished result is delivered once the output slot frees.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == xrrg_pkg::BK_DONE && out_free) |=>
      (!rsp_empty && state_ff == xrrg_pkg::BK_IDLE))
      else $error("result not moved to output register");

endmodule

/* rtl/xorshift_rotate_random_generator.sv */
// Xorshift/rotate random generator with raw, range and fraction draws.
// A front end advances the two state words and classifies each request, a
// short job queue decouples it from a back end that scrambles the draw and
// reduces range draws with a radix-2 remainder unit, one bit per cycle.
// Seed requests give no transaction. Raw and fraction draws pass through
// scale, multiply and done in the back end; range draws add the 64 steps of
// the remainder unit (none for a full range) and an addition. While the back
// end works, the front end keeps accepting requests until the queue is full.
// Depends on xrrg_pkg, xrrg_front, xrrg_queue and xrrg_back.
module xorshift_rotate_random_generator #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [xrrg_pkg::OP_W-1:0]         req_op,
   input  logic [xrrg_pkg::WORD_W-1:0]       req_low_bound,
   input  logic [xrrg_pkg::WORD_W-1:0]       req_high_bound,
   input  logic [xrrg_pkg::WORD_W-1:0]       req_seed_value,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [xrrg_pkg::WORD_W-1:0]       rsp_value
);

   xrrg_pkg::job_type push_job;
   xrrg_pkg::job_type head_job;
   logic              job_push;
   logic              queue_full;
   logic              queue_empty;
   logic              job_pop;

   xrrg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_op         (req_op),
      .req_low_bound  (req_low_bound),
      .req_high_bound (req_high_bound),
      .req_seed_value (req_seed_value),
      .job_push       (job_push),
      .job_data       (push_job),
      .queue_full     (queue_full)
   );

   xrrg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .full      (queue_full),
      .pop       (job_pop),
      .pop_data  (head_job),
      .empty     (queue_empty)
   );

   xrrg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!queue_empty),
      .job_data  (head_job),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_value (rsp_value)
   );

endmodule
